// ===== rtl/core/gded_pkg.sv =====
// types and constants shared by the group debounced edge detector
`timescale 1ns / 1ps
`default_nettype none
package gded_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned PHASE_W = 2;

  // per-pin status codes
  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_ON      = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_RISING  = 3'd3,
    ST_FALLING = 3'd4
  } pin_status_t;

  // machine phase, one-hot
  typedef enum logic [2:0] {
    PH_CHECK  = 3'b001,
    PH_WAIT   = 3'b010,
    PH_UPDATE = 3'b100
  } phase_t;

  // phase codes as reported on the result word
  localparam logic [PHASE_W-1:0] PHASE_CODE_CHECK  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_WAIT   = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_UPDATE = 2'd2;

  // configuration register indexes
  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_PIN_ENABLE     = 1'b1;

  // phase actions handed to each pin slice
  typedef struct packed {
    logic do_check;
    logic do_update;
  } pin_ctrl_t;

  // per-pin contribution to the result masks
  typedef struct packed {
    logic on;
    logic unknown;
    logic rising;
    logic falling;
  } pin_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/gded_pin_slice.sv =====
// next status and result flags of one pin
`timescale 1ns / 1ps
`default_nettype none
module gded_pin_slice
  import gded_pkg::*;
(
  input  wire logic        level,
  input  wire logic        stable,
  input  wire logic        watched,
  input  wire pin_ctrl_t   ctrl,
  input  wire pin_status_t status,
  output pin_status_t      status_nxt,
  output logic             changed,
  output pin_flags_t       flags
);

  logic differs;

  assign differs = level ^ stable;
  assign changed = ctrl.do_check && watched && differs;

  always_comb begin
    status_nxt = status;
    if (watched) begin
      if (ctrl.do_check) begin
        if (differs) begin
          status_nxt = ST_UNKNOWN;
        end else begin
          status_nxt = level ? ST_ON : ST_OFF;
        end
      end else if (ctrl.do_update && differs) begin
        status_nxt = level ? ST_RISING : ST_FALLING;
      end
    end
  end

  // unwatched pins read as zero in every mask
  always_comb begin
    flags = '0;
    if (watched) begin
      case (status_nxt)
        ST_ON:      flags.on      = 1'b1;
        ST_UNKNOWN: flags.unknown = 1'b1;
        ST_RISING:  flags.rising  = 1'b1;
        ST_FALLING: flags.falling = 1'b1;
        default:    flags         = '0;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/group_debounced_edge_detector.sv =====
// group debounced edge detector: per-pin debounce with a check/wait/update machine
//
// usage: each input word carries one sample of all pin levels (in_pin_levels)
// and the current free-running tick (in_tick_now). every accepted word gives
// exactly one result word: the on, unknown, rising and falling masks of the
// watched pins and the machine phase after that step.
// cfg_wr_en writes debounce_ticks (index 0) or pin_enable (index 1) in the
// same cycle; write only while no word is in flight.
// latency: the result word is valid the cycle after the input word is taken.
// throughput: one word per cycle. in_ready stays high while the result
// register is empty or being drained, so a stalled receiver holds one result
// and stops input only after that.
// reset (rst_n low, synchronous) clears both registers, all pin statuses to
// off, the phase to check and the primed flag. the first word after reset
// only loads the stable levels and start tick and reports the reset statuses.
// elapsed time in wait is tick minus start tick modulo 2^32.
`timescale 1ns / 1ps
`default_nettype none
module group_debounced_edge_detector
  import gded_pkg::*;
#(
  parameter int unsigned NUM_PINS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_index,
  input  wire logic [WORD_W-1:0]   cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [WORD_W-1:0]   in_pin_levels,
  input  wire logic [WORD_W-1:0]   in_tick_now,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [WORD_W-1:0]        out_on_mask,
  output logic [WORD_W-1:0]        out_unknown_mask,
  output logic [WORD_W-1:0]        out_rising_mask,
  output logic [WORD_W-1:0]        out_falling_mask,
  output logic [PHASE_W-1:0]       out_phase
);

  logic [WORD_W-1:0]   debounce_ticks_r;
  logic [WORD_W-1:0]   pin_enable_r;
  logic [NUM_PINS-1:0] stable_levels_r;
  logic [NUM_PINS-1:0] stable_levels_nxt;
  logic [WORD_W-1:0]   start_tick_r;
  logic [WORD_W-1:0]   start_tick_nxt;
  logic                primed_r;
  phase_t              phase_r;
  phase_t              phase_nxt;
  pin_status_t         status_r   [NUM_PINS];
  pin_status_t         status_nxt [NUM_PINS];
  pin_flags_t          flags      [NUM_PINS];
  logic [NUM_PINS-1:0] changed;
  logic [NUM_PINS-1:0] levels;
  logic [NUM_PINS-1:0] watched;
  pin_ctrl_t           ctrl;
  logic [WORD_W-1:0]   elapsed;
  logic                wait_done;
  logic                accept;

  logic                out_valid_r;
  logic [WORD_W-1:0]   on_mask_r, on_mask_nxt;
  logic [WORD_W-1:0]   unknown_mask_r, unknown_mask_nxt;
  logic [WORD_W-1:0]   rising_mask_r, rising_mask_nxt;
  logic [WORD_W-1:0]   falling_mask_r, falling_mask_nxt;
  logic [PHASE_W-1:0]  phase_code_r, phase_code_nxt;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign levels    = in_pin_levels[NUM_PINS-1:0];
  assign watched   = pin_enable_r[NUM_PINS-1:0];
  assign elapsed   = in_tick_now - start_tick_r;
  assign wait_done = elapsed >= debounce_ticks_r;

  always_comb begin
    ctrl.do_check  = 1'b0;
    ctrl.do_update = 1'b0;
    if (primed_r) begin
      case (phase_r)
        PH_WAIT:   ctrl = '0;
        PH_UPDATE: ctrl.do_update = 1'b1;
        default:   ctrl.do_check = 1'b1;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_PINS; i++) begin : g_pin
    gded_pin_slice u_slice (
      .level      (levels[i]),
      .stable     (stable_levels_r[i]),
      .watched    (watched[i]),
      .ctrl       (ctrl),
      .status     (status_r[i]),
      .status_nxt (status_nxt[i]),
      .changed    (changed[i]),
      .flags      (flags[i])
    );
  end

  always_comb begin
    phase_nxt         = phase_r;
    stable_levels_nxt = stable_levels_r;
    start_tick_nxt    = start_tick_r;
    if (!primed_r) begin
      stable_levels_nxt = levels;
      start_tick_nxt    = in_tick_now;
    end else begin
      case (phase_r)
        PH_WAIT: begin
          if (wait_done) phase_nxt = PH_UPDATE;
        end
        PH_UPDATE: begin
          phase_nxt         = PH_CHECK;
          stable_levels_nxt = levels;
          start_tick_nxt    = in_tick_now;
        end
        default: begin
          phase_nxt = (|changed) ? PH_WAIT : PH_CHECK;
        end
      endcase
    end
  end

  always_comb begin
    on_mask_nxt      = '0;
    unknown_mask_nxt = '0;
    rising_mask_nxt  = '0;
    falling_mask_nxt = '0;
    for (int i = 0; i < NUM_PINS; i++) begin
      on_mask_nxt[i]      = flags[i].on;
      unknown_mask_nxt[i] = flags[i].unknown;
      rising_mask_nxt[i]  = flags[i].rising;
      falling_mask_nxt[i] = flags[i].falling;
    end
    case (phase_nxt)
      PH_WAIT:   phase_code_nxt = PHASE_CODE_WAIT;
      PH_UPDATE: phase_code_nxt = PHASE_CODE_UPDATE;
      default:   phase_code_nxt = PHASE_CODE_CHECK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= '0;
      pin_enable_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_data;
        REG_PIN_ENABLE:     pin_enable_r     <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r        <= 1'b0;
      phase_r         <= PH_CHECK;
      stable_levels_r <= '0;
      start_tick_r    <= '0;
      for (int i = 0; i < NUM_PINS; i++) begin
        status_r[i] <= ST_OFF;
      end
    end else if (accept) begin
      primed_r        <= 1'b1;
      phase_r         <= phase_nxt;
      stable_levels_r <= stable_levels_nxt;
      start_tick_r    <= start_tick_nxt;
      for (int i = 0; i < NUM_PINS; i++) begin
        status_r[i] <= status_nxt[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      on_mask_r      <= on_mask_nxt;
      unknown_mask_r <= unknown_mask_nxt;
      rising_mask_r  <= rising_mask_nxt;
      falling_mask_r <= falling_mask_nxt;
      phase_code_r   <= phase_code_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_on_mask      = on_mask_r;
  assign out_unknown_mask = unknown_mask_r;
  assign out_rising_mask  = rising_mask_r;
  assign out_falling_mask = falling_mask_r;
  assign out_phase        = phase_code_r;

endmodule
`default_nettype wire
